// File: design/bpie_pkg.sv
// Shared types and codes for the buffer pool with idle-age eviction.
// No dependencies; imported by the controller, the datapath and the top level.
package bpie_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 16;
    localparam logic [7:0]  IDLE_LIMIT_RST = 8'd3;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_GET    = 2'd0;
    localparam t_opcode OP_RETURN = 2'd1;
    localparam t_opcode OP_TICK   = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_UNKNOWN = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch the accepted word, restart the scan
        logic scan_en;  // step the size scan
        logic commit;   // update the table and load the result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_dp_sts;

endpackage

// File: design/bpie_ctrl.sv
// Request sequencer for the buffer pool: idle, size scan, commit.
// Depends on bpie_pkg for the opcode codes and command/status structs.
module bpie_ctrl
    import bpie_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_opcode i_opcode,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   accept;

    assign accept       = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cmd.load    = accept;
    assign o_cmd.scan_en = (r_state == S_SCAN);
    assign o_cmd.commit  = (r_state == S_COMMIT) && i_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= (i_opcode == OP_GET) ? S_SCAN : S_COMMIT;
                    end
                end
                S_SCAN: begin
                    if (i_sts.scan_done) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/bpie_dp.sv
// Slot table, size memory scan, tick/evict lanes and result register.
// Depends on bpie_pkg; driven by bpie_ctrl through t_dp_cmd / t_dp_sts.
module bpie_dp
    import bpie_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_opcode     i_opcode,
    input  logic [31:0] i_request_size,
    input  logic [3:0]  i_slot_handle,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_granted_slot,
    output logic        o_reused,
    output t_status     o_status
);

    localparam int unsigned IDXW = $clog2(SLOT_COUNT);
    localparam int unsigned ISSW = $clog2(SLOT_COUNT + 1);
    localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(SLOT_COUNT - 1);
    localparam logic [ISSW-1:0] ISS_END   = ISSW'(SLOT_COUNT);

    // slot table
    logic            r_valid [SLOT_COUNT];
    logic            r_taken [SLOT_COUNT];
    logic [7:0]      r_age   [SLOT_COUNT];
    logic [31:0]     r_mem   [SLOT_COUNT];
    logic [7:0]      r_idle_limit;

    // latched request
    t_opcode         r_op;
    logic [31:0]     r_want;
    logic [3:0]      r_handle;

    // scan
    logic [ISSW-1:0] r_iss;
    logic [31:0]     r_rd_data;
    logic [IDXW-1:0] r_rd_idx;
    logic            r_rd_vld;
    logic            r_hit;
    logic [IDXW-1:0] r_hit_idx;
    logic            r_emp_found;
    logic [IDXW-1:0] r_emp_idx;
    logic            r_done;

    // result register
    logic            r_out_valid;
    logic [3:0]      r_granted_slot;
    logic            r_reused;
    t_status         r_status;

    logic            iss_en;
    logic            cmp_en;
    logic            out_free;
    logic            hdl_ok;
    logic [IDXW-1:0] hdl_idx;
    logic            do_claim;
    logic [7:0]      n_age   [SLOT_COUNT];
    logic            evict   [SLOT_COUNT];

    assign iss_en   = i_cmd.scan_en && (r_iss != ISS_END);
    assign cmp_en   = r_rd_vld && !r_done;
    assign out_free = !r_out_valid || !i_out_stall;
    assign hdl_idx  = IDXW'(r_handle);
    assign hdl_ok   = (32'(r_handle) < 32'(SLOT_COUNT)) && r_valid[hdl_idx];
    assign do_claim = i_cmd.commit && (r_op == OP_GET) && !r_hit && r_emp_found;

    assign o_sts.scan_done = r_done;
    assign o_sts.out_free  = out_free;

    // tick lanes: age free slots, then evict on limit
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            n_age[i] = r_age[i];
            if (r_valid[i] && !r_taken[i] && (r_age[i] != 8'hFF)) begin
                n_age[i] = r_age[i] + 8'd1;
            end
            evict[i] = r_valid[i] && (n_age[i] >= r_idle_limit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= IDLE_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            r_idle_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_want   <= i_request_size;
            r_handle <= i_slot_handle;
        end
    end

    // size memory: one read port for the scan, one write port for claims
    always_ff @(posedge i_clk) begin
        if (iss_en) begin
            r_rd_data <= r_mem[r_iss[IDXW-1:0]];
        end
        if (do_claim) begin
            r_mem[r_emp_idx] <= r_want;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss       <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_idx    <= '0;
            r_hit       <= 1'b0;
            r_hit_idx   <= '0;
            r_emp_found <= 1'b0;
            r_emp_idx   <= '0;
            r_done      <= 1'b0;
        end else if (i_cmd.load) begin
            r_iss       <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_emp_found <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_rd_vld <= iss_en;
            if (iss_en) begin
                r_rd_idx <= r_iss[IDXW-1:0];
                r_iss    <= r_iss + ISSW'(1);
            end
            if (cmp_en) begin
                if (r_valid[r_rd_idx] && !r_taken[r_rd_idx] && (r_rd_data == r_want)) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                    r_done    <= 1'b1;
                end else begin
                    if (!r_valid[r_rd_idx] && !r_emp_found) begin
                        r_emp_found <= 1'b1;
                        r_emp_idx   <= r_rd_idx;
                    end
                    if (r_rd_idx == LAST_IDX) begin
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_valid[i] <= 1'b0;
                r_taken[i] <= 1'b0;
            end
        end else if (i_cmd.commit) begin
            case (r_op)
                OP_GET: begin
                    if (r_hit) begin
                        r_taken[r_hit_idx] <= 1'b1;
                    end else if (r_emp_found) begin
                        r_valid[r_emp_idx] <= 1'b1;
                        r_taken[r_emp_idx] <= 1'b1;
                    end
                end
                OP_RETURN: begin
                    if (hdl_ok) begin
                        r_taken[hdl_idx] <= 1'b0;
                    end
                end
                OP_TICK: begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (evict[i]) begin
                            r_valid[i] <= 1'b0;
                            r_taken[i] <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ages are only read for valid slots, and a claim zeroes them
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            case (r_op)
                OP_GET: begin
                    if (r_hit) begin
                        r_age[r_hit_idx] <= 8'd0;
                    end else if (r_emp_found) begin
                        r_age[r_emp_idx] <= 8'd0;
                    end
                end
                OP_TICK: begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        r_age[i] <= evict[i] ? 8'd0 : n_age[i];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_granted_slot <= 4'd0;
            r_reused       <= 1'b0;
            r_status       <= ST_OK;
            case (r_op)
                OP_GET: begin
                    if (r_hit) begin
                        r_granted_slot <= 4'(r_hit_idx);
                        r_reused       <= 1'b1;
                    end else if (r_emp_found) begin
                        r_granted_slot <= 4'(r_emp_idx);
                    end else begin
                        r_status <= ST_FULL;
                    end
                end
                OP_RETURN: begin
                    if (!hdl_ok) begin
                        r_status <= ST_UNKNOWN;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_granted_slot = r_granted_slot;
    assign o_reused       = r_reused;
    assign o_status       = r_status;

endmodule

// File: design/buffer_pool_idle_eviction_top.sv
// Buffer pool with idle-age eviction, top level: sequencer plus slot datapath.
// Get: scans the size memory lowest slot first, one size compare per cycle
// through the size memory's single read port, stopping early when a slot matches.
// Return, tick and the spare opcode skip the scan. One word in flight at a time.
// Synchronous active-low reset empties the pool and sets idle_limit to 3.
module buffer_pool_idle_eviction_top
    import bpie_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_request_size,
    input  logic [3:0]  i_slot_handle,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_granted_slot,
    output logic        o_reused,
    output logic [1:0]  o_status,
    // idle_limit register
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer: takes a word only when idle, runs the size scan for a get,
    // then waits in commit until the result register can take the answer.
    bpie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd),
        .i_sts      (dp_sts)
    );

    // Datapath: valid/taken/age per slot in flops, sizes in a one-read,
    // one-write memory scanned lowest slot first. Table updates and the
    // result register load happen together on commit.
    bpie_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_opcode       (i_opcode),
        .i_request_size (i_request_size),
        .i_slot_handle  (i_slot_handle),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_granted_slot (o_granted_slot),
        .o_reused       (o_reused),
        .o_status       (o_status)
    );

    // An accepted word makes the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block not busy after accepting a word");

    // A result is never loaded over one still waiting downstream.
    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.commit |-> dp_sts.out_free)
        else $error("commit while result register is stalled");

    // The result valid only rises right after a commit.
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(dp_cmd.commit))
        else $error("result valid without commit");

    // No scan step while the block is idle.
    a_scan_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.scan_en |-> o_in_stall)
        else $error("scan running while idle");

endmodule
